@@ rtl/core/erp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the edge rotate and project pipeline.
// No dependencies.
package erp_pkg;

    localparam int SIN_FRAC     = 14;
    localparam int DIST_FRAC    = 12;
    localparam int COORD_W      = 16;
    localparam int OW           = 46;   // rotated coordinate width
    localparam int QBITS        = 11;   // quotient magnitude bits below saturation
    localparam int ROT_STAGES   = 3;
    localparam int PROJ_STAGES  = QBITS + 3;
    localparam int NST          = 1 + ROT_STAGES + PROJ_STAGES + 1;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [1:0] {
        REG_CENTER_X      = 2'd0,
        REG_CENTER_Y      = 2'd1,
        REG_FOCAL_LENGTH  = 2'd2,
        REG_VIEW_DISTANCE = 2'd3
    } cfg_reg_t;

endpackage

@@ rtl/core/erp_ifs.sv @@
`timescale 1ns / 1ps
// Channel interfaces: edge items in, line items out, register writes.
// No dependencies.
interface erp_edge_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, angle_x, angle_y,
                    input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, angle_x, angle_y,
                  output ready);
endinterface

interface erp_line_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
    logic [7:0]         grey_level;
    logic               behind_viewer;
    modport source (output valid, start_x, start_y, end_x, end_y, grey_level,
                    behind_viewer, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, grey_level,
                  behind_viewer, output ready);
endinterface

interface erp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/erp_sine.sv @@
`timescale 1ns / 1ps
// Sine and cosine of both angles from a quarter-wave constant table, registered.
// Depends on erp_pkg.
module erp_sine #(
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle_x,
    input  logic [15:0]        angle_y,
    output logic signed [15:0] sx_reg,
    output logic signed [15:0] cx_reg,
    output logic signed [15:0] sy_reg,
    output logic signed [15:0] cy_reg
);
    import erp_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PW = SIN_FRAC + IW;
    localparam longint ONE_Q30 = longint'(1) << 30;

    logic [14:0] rom [0:SINE_TABLE_ENTRIES];

    // odd Taylor series, x in Q30 radians
    for (genvar gi = 0; gi <= SINE_TABLE_ENTRIES; gi++)
    begin : g_rom
        localparam longint X   = HALF_PI_Q30 * longint'(gi) / SINE_TABLE_ENTRIES;
        localparam longint X2  = X * X / ONE_Q30;
        localparam longint T1  = -((X * X2 / ONE_Q30) / 6);
        localparam longint T2  = -((T1 * X2 / ONE_Q30) / 20);
        localparam longint T3  = -((T2 * X2 / ONE_Q30) / 42);
        localparam longint T4  = -((T3 * X2 / ONE_Q30) / 72);
        localparam longint T5  = -((T4 * X2 / ONE_Q30) / 110);
        localparam longint T6  = -((T5 * X2 / ONE_Q30) / 156);
        localparam longint T7  = -((T6 * X2 / ONE_Q30) / 210);
        localparam longint T8  = -((T7 * X2 / ONE_Q30) / 272);
        localparam longint T9  = -((T8 * X2 / ONE_Q30) / 342);
        localparam longint T10 = -((T9 * X2 / ONE_Q30) / 420);
        localparam longint T11 = -((T10 * X2 / ONE_Q30) / 506);
        localparam longint T12 = -((T11 * X2 / ONE_Q30) / 600);
        localparam longint SUM = X + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9 + T10
                                 + T11 + T12;
        localparam longint V   = (SUM < 0) ? 0 : (SUM + 32768) / 65536;
        localparam logic [14:0] ENTRY = (V > 16384) ? 15'd16384 : 15'(V);
        assign rom[gi] = ENTRY;
    end

    function automatic logic signed [15:0] lookup(input logic [15:0] a);
        logic [1:0]         quad;
        logic [PW-1:0]      prod;
        logic [IW-1:0]      idx;
        logic [IW-1:0]      addr;
        logic signed [15:0] v;
        quad = a[15:14];
        prod = PW'(a[13:0]) * PW'(SINE_TABLE_ENTRIES);
        idx  = prod[PW-1:SIN_FRAC];
        addr = quad[0] ? (IW'(SINE_TABLE_ENTRIES) - idx) : idx;
        v    = $signed({1'b0, rom[addr]});
        return quad[1] ? -v : v;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= lookup(angle_x);
            cx_reg <= lookup(angle_x + 16'd16384);
            sy_reg <= lookup(angle_y);
            cy_reg <= lookup(angle_y + 16'd16384);
        end
    end

endmodule

@@ rtl/core/erp_rotate.sv @@
`timescale 1ns / 1ps
// Rotation of one endpoint about X then Y, plus depth with viewer distance.
// Three register stages. Depends on erp_pkg.
module erp_rotate #(
    parameter int DW = 47
) (
    input  logic                     clk,
    input  logic [erp_pkg::ROT_STAGES-1:0] en,
    input  logic signed [15:0]       ix,
    input  logic signed [15:0]       iy,
    input  logic signed [15:0]       iz,
    input  logic signed [15:0]       sx,
    input  logic signed [15:0]       cx,
    input  logic signed [15:0]       sy,
    input  logic signed [15:0]       cy,
    input  logic signed [DW-1:0]     dist_off,
    output logic signed [erp_pkg::OW-1:0] ox_reg,
    output logic signed [erp_pkg::OW-1:0] oy_reg,
    output logic signed [erp_pkg::OW-1:0] oz_reg,
    output logic signed [DW-1:0]     d_reg,
    output logic                     behind_reg
);
    import erp_pkg::*;

    logic signed [31:0] y1_reg, z1_reg;
    logic signed [15:0] ix_reg, sy_reg, cy_reg;
    logic signed [31:0] p1_reg, p3_reg;
    logic signed [47:0] p2_reg, p4_reg;
    logic signed [OW-1:0] oy_mid_reg;
    logic signed [OW-1:0] ox_next, oz_next;
    logic signed [DW-1:0] d_next;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            y1_reg <= 32'(iy * cx) - 32'(iz * sx);
            z1_reg <= 32'(iy * sx) + 32'(iz * cx);
            ix_reg <= ix;
            sy_reg <= sy;
            cy_reg <= cy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p1_reg     <= 32'(ix_reg * cy_reg);
            p3_reg     <= 32'(ix_reg * sy_reg);
            p2_reg     <= 48'(z1_reg * sy_reg);
            p4_reg     <= 48'(z1_reg * cy_reg);
            oy_mid_reg <= OW'(y1_reg) <<< SIN_FRAC;
        end
    end

    always_comb
    begin
        ox_next = (OW'(p1_reg) <<< SIN_FRAC) + OW'(p2_reg);
        oz_next = OW'(p4_reg) - (OW'(p3_reg) <<< SIN_FRAC);
        d_next  = DW'(oz_next) + dist_off;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ox_reg     <= ox_next;
            oy_reg     <= oy_mid_reg;
            oz_reg     <= oz_next;
            d_reg      <= d_next;
            behind_reg <= (d_next <= 0);
        end
    end

endmodule

@@ rtl/core/erp_proj.sv @@
`timescale 1ns / 1ps
// Projection of one coordinate: (p*f + c*d) / d, truncated, saturated to 12 bits.
// Restoring divider, one quotient bit per stage. Depends on erp_pkg.
module erp_proj #(
    parameter int DW = 47
) (
    input  logic                       clk,
    input  logic [erp_pkg::PROJ_STAGES-1:0] en,
    input  logic signed [erp_pkg::OW-1:0] p,
    input  logic signed [DW-1:0]       d,
    input  logic [9:0]                 c,
    input  logic [9:0]                 f,
    output logic signed [11:0]         q
);
    import erp_pkg::*;

    localparam int M1W = OW + 11;
    localparam int M2W = DW + 11;
    localparam int NW  = ((M1W > M2W) ? M1W : M2W) + 1;
    localparam int DS  = QBITS + 1;   // divider stages, first checks overflow

    logic signed [M1W-1:0] m1_reg;
    logic signed [M2W-1:0] m2_reg;
    logic signed [DW-1:0]  d0_reg, d1_reg;
    logic [NW-1:0]         mag_reg;
    logic                  neg_reg;
    logic signed [NW-1:0]  n_sum;

    logic [NW-1:0]    rem_reg [0:DS-1];
    logic [QBITS-1:0] qb_reg  [0:DS-1];
    logic [NW-1:0]    dd_reg  [0:DS-1];
    logic             ovf_reg [0:DS-1];
    logic             sgn_reg [0:DS-1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m1_reg <= M1W'(p * $signed({1'b0, f}));
            m2_reg <= M2W'(d * $signed({1'b0, c}));
            d0_reg <= d;
        end
    end

    assign n_sum = NW'(m1_reg) + NW'(m2_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            neg_reg <= n_sum[NW-1];
            mag_reg <= n_sum[NW-1] ? NW'(-n_sum) : NW'(n_sum);
            d1_reg  <= d0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rem_reg[0] <= mag_reg;
            qb_reg[0]  <= '0;
            dd_reg[0]  <= NW'($unsigned(d1_reg));
            ovf_reg[0] <= (mag_reg >= (NW'($unsigned(d1_reg)) << QBITS));
            sgn_reg[0] <= neg_reg;
        end
    end

    for (genvar j = 1; j < DS; j++)
    begin : g_div
        localparam int B = QBITS - j;
        logic [NW-1:0] sub;
        logic          fits;
        assign sub  = dd_reg[j-1] << B;
        assign fits = (rem_reg[j-1] >= sub);
        always_ff @(posedge clk)
        begin
            if (en[j+2])
            begin
                rem_reg[j] <= fits ? (rem_reg[j-1] - sub) : rem_reg[j-1];
                qb_reg[j]  <= qb_reg[j-1] | (fits ? (QBITS'(1) << B) : '0);
                dd_reg[j]  <= dd_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                sgn_reg[j] <= sgn_reg[j-1];
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[DS-1])
            q = sgn_reg[DS-1] ? -12'sd2048 : 12'sd2047;
        else if (sgn_reg[DS-1])
            q = -$signed({1'b0, qb_reg[DS-1]});
        else
            q = $signed({1'b0, qb_reg[DS-1]});
    end

endmodule

@@ rtl/core/edge_rotate_project_unit.sv @@
`timescale 1ns / 1ps
// Edge rotate and project unit: top level with registers and pipeline control.
// Depends on erp_pkg, erp_ifs, erp_sine, erp_rotate, erp_proj.
// One edge per cycle is sustained while line_ch.ready does not stall the output;
// the 19-stage pipeline holds a one-bit-per-stage divider per coordinate.
// Stalls fill bubbles first; rst_n clears all valid bits and loads register defaults.
module edge_rotate_project_unit #(
    parameter int COORD_FRAC_BITS    = 12,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic clk,
    input  logic rst_n,
    erp_cfg_if.sink    cfg,
    erp_edge_if.sink   edge_ch,
    erp_line_if.source line_ch
);
    import erp_pkg::*;

    localparam int DSH = COORD_FRAC_BITS + 2 * SIN_FRAC - DIST_FRAC;
    localparam int DW  = (DSH + 18 > 47) ? DSH + 18 : 47;
    localparam int GW  = (COORD_FRAC_BITS + 40 > 57) ? COORD_FRAC_BITS + 40 : 57;
    localparam int GSH = COORD_FRAC_BITS + 2 * SIN_FRAC + 2;
    localparam logic signed [GW-1:0] GREY_K =
        GW'(670) <<< (COORD_FRAC_BITS + 2 * SIN_FRAC);
    localparam int S_ROT  = 1;
    localparam int S_PROJ = S_ROT + ROT_STAGES;
    localparam int S_OUT  = NST - 1;

    logic [9:0]  center_x_reg, center_y_reg, focal_length_reg;
    logic [15:0] view_distance_reg;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg      <= 10'd120;
            center_y_reg      <= 10'd120;
            focal_length_reg  <= 10'd180;
            view_distance_reg <= 16'd20480;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_CENTER_X:      center_x_reg      <= cfg.data[9:0];
                REG_CENTER_Y:      center_y_reg      <= cfg.data[9:0];
                REG_FOCAL_LENGTH:  focal_length_reg  <= cfg.data[9:0];
                REG_VIEW_DISTANCE: view_distance_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

    // pipeline control: a stage loads when empty or when the next one loads
    assign en[S_OUT] = !v_reg[S_OUT] || line_ch.ready;
    for (genvar k = 0; k < S_OUT; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign edge_ch.ready = en[0];
    assign line_ch.valid = v_reg[S_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                    v_reg[k] <= (k == 0) ? edge_ch.valid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // stage 0: table lookup and input capture
    logic signed [15:0] sx, cx, sy, cy;
    logic signed [15:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;

    erp_sine #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_sine (
        .clk     (clk),
        .en      (en[0]),
        .angle_x (edge_ch.angle_x),
        .angle_y (edge_ch.angle_y),
        .sx_reg  (sx),
        .cx_reg  (cx),
        .sy_reg  (sy),
        .cy_reg  (cy)
    );

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ax_reg <= edge_ch.a_x;
            ay_reg <= edge_ch.a_y;
            az_reg <= edge_ch.a_z;
            bx_reg <= edge_ch.b_x;
            by_reg <= edge_ch.b_y;
            bz_reg <= edge_ch.b_z;
        end
    end

    // rotation
    logic signed [DW-1:0] dist_off;
    logic signed [OW-1:0] oxa, oya, oza, oxb, oyb, ozb;
    logic signed [DW-1:0] da, db;
    logic                 bha, bhb;

    assign dist_off = $signed(DW'(view_distance_reg) << DSH);

    erp_rotate #(.DW(DW)) u_rot_a (
        .clk (clk), .en (en[S_PROJ-1:S_ROT]),
        .ix (ax_reg), .iy (ay_reg), .iz (az_reg),
        .sx (sx), .cx (cx), .sy (sy), .cy (cy), .dist_off (dist_off),
        .ox_reg (oxa), .oy_reg (oya), .oz_reg (oza), .d_reg (da), .behind_reg (bha)
    );

    erp_rotate #(.DW(DW)) u_rot_b (
        .clk (clk), .en (en[S_PROJ-1:S_ROT]),
        .ix (bx_reg), .iy (by_reg), .iz (bz_reg),
        .sx (sx), .cx (cx), .sy (sy), .cy (cy), .dist_off (dist_off),
        .ox_reg (oxb), .oy_reg (oyb), .oz_reg (ozb), .d_reg (db), .behind_reg (bhb)
    );

    // projection
    logic signed [11:0] qax, qay, qbx, qby;

    erp_proj #(.DW(DW)) u_proj_ax (
        .clk (clk), .en (en[S_OUT-1:S_PROJ]), .p (oxa), .d (da),
        .c (center_x_reg), .f (focal_length_reg), .q (qax)
    );
    erp_proj #(.DW(DW)) u_proj_ay (
        .clk (clk), .en (en[S_OUT-1:S_PROJ]), .p (oya), .d (da),
        .c (center_y_reg), .f (focal_length_reg), .q (qay)
    );
    erp_proj #(.DW(DW)) u_proj_bx (
        .clk (clk), .en (en[S_OUT-1:S_PROJ]), .p (oxb), .d (db),
        .c (center_x_reg), .f (focal_length_reg), .q (qbx)
    );
    erp_proj #(.DW(DW)) u_proj_by (
        .clk (clk), .en (en[S_OUT-1:S_PROJ]), .p (oyb), .d (db),
        .c (center_y_reg), .f (focal_length_reg), .q (qby)
    );

    // depth cue and behind flags, aligned with the projection stages
    logic signed [OW:0]   zsum;
    logic signed [GW-1:0] num_reg;
    logic signed [GW-1:0] gshift;
    logic [7:0]           grey_val;
    logic [7:0]           grey_pipe [S_PROJ+1:S_OUT-1];
    logic                 bha_pipe  [S_PROJ:S_OUT-1];
    logic                 bhb_pipe  [S_PROJ:S_OUT-1];

    assign zsum = (OW + 1)'(oza) + (OW + 1)'(ozb);

    always_ff @(posedge clk)
    begin
        if (en[S_PROJ])
        begin
            num_reg     <= GREY_K - GW'(zsum) * GW'(175);
            bha_pipe[S_PROJ] <= bha;
            bhb_pipe[S_PROJ] <= bhb;
        end
    end

    assign gshift = num_reg >>> GSH;

    always_comb
    begin
        if (num_reg <= 0)
            grey_val = 8'd0;
        else if (gshift > 255)
            grey_val = 8'd255;
        else
            grey_val = gshift[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[S_PROJ+1])
            grey_pipe[S_PROJ+1] <= grey_val;
    end

    for (genvar k = S_PROJ + 1; k < S_OUT; k++)
    begin : g_bh
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                bha_pipe[k] <= bha_pipe[k-1];
                bhb_pipe[k] <= bhb_pipe[k-1];
            end
        end
    end

    for (genvar k = S_PROJ + 2; k < S_OUT; k++)
    begin : g_grey
        always_ff @(posedge clk)
        begin
            if (en[k])
                grey_pipe[k] <= grey_pipe[k-1];
        end
    end

    // output register
    logic signed [11:0] cxs, cys;

    assign cxs = $signed({2'b00, center_x_reg});
    assign cys = $signed({2'b00, center_y_reg});

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            line_ch.start_x       <= bha_pipe[S_OUT-1] ? cxs : qax;
            line_ch.start_y       <= bha_pipe[S_OUT-1] ? cys : qay;
            line_ch.end_x         <= bhb_pipe[S_OUT-1] ? cxs : qbx;
            line_ch.end_y         <= bhb_pipe[S_OUT-1] ? cys : qby;
            line_ch.grey_level    <= grey_pipe[S_OUT-1];
            line_ch.behind_viewer <= bha_pipe[S_OUT-1] | bhb_pipe[S_OUT-1];
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for edge_rotate_project_unit: directed table, then random edges
// checked against a bit-exact rotation and projection predictor under random handshakes.
// Depends on erp_pkg, erp_ifs and the unit RTL.
module testbench;
    import erp_pkg::*;

    localparam longint CYCLE_LIMIT = 500000;
    localparam int     LAT_WAIT    = 40;

    typedef struct {
        logic signed [15:0] ax, ay, az, bx, by, bz;
        logic [15:0]        angx, angy;
    } edge_item_t;

    typedef struct {
        logic signed [11:0] sx, sy, ex, ey;
        logic [7:0]         grey;
        logic               behind;
    } line_item_t;

    typedef struct {
        edge_item_t e;
        bit         typed;
        line_item_t l;
    } table_row_t;

    logic clk;
    logic rst_n;

    erp_cfg_if  cfg_bus ();
    erp_edge_if edge_bus ();
    erp_line_if line_bus ();

    edge_rotate_project_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .edge_ch (edge_bus),
        .line_ch (line_bus)
    );

    longint     sine_tab [0:256];
    logic [9:0] cx_reg, cy_reg, fl_reg;
    logic [15:0] vd_reg;
    line_item_t lines_due [$];
    int         errors;
    int         send_pct;
    int         recv_pct;
    bit         hold_req;
    int         hold_cnt;
    longint     cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint tab_value(longint i);
        longint x, x2, term, sum, v;
        int     k;
        x    = HALF_PI_Q30 * i / 256;
        x2   = x * x / (64'sd1 <<< 30);
        term = x;
        sum  = x;
        for (k = 1; k <= 12; k++)
        begin
            term = term * x2 / (64'sd1 <<< 30);
            term = -(term / longint'((2 * k) * (2 * k + 1)));
            sum  = sum + term;
        end
        if (sum < 0)
            sum = 0;
        v = (sum + 32768) / 65536;
        if (v > 16384)
            v = 16384;
        return v;
    endfunction

    function automatic longint sine_lookup(logic [15:0] a);
        logic [7:0] idx;
        longint     v;
        idx = a[13:6];
        v   = a[14] ? sine_tab[256 - idx] : sine_tab[idx];
        return a[15] ? -v : v;
    endfunction

    function automatic longint clip12(longint v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    function automatic bit project_point(longint ix, longint iy, longint iz, longint sx,
                                         longint cx, longint sy, longint cy,
                                         output longint px, output longint py,
                                         output longint pz);
        longint y1, z1, ox, oy, oz, d;
        y1 = iy * cx - iz * sx;
        z1 = iy * sx + iz * cx;
        ox = ix * cy * 16384 + z1 * sy;
        oy = y1 * 16384;
        oz = -(ix * sy * 16384) + z1 * cy;
        d  = oz + (longint'(vd_reg) <<< 28);
        pz = oz;
        if (d <= 0)
        begin
            px = cx_reg;
            py = cy_reg;
            return 1'b1;
        end
        px = clip12((ox * longint'(fl_reg) + longint'(cx_reg) * d) / d);
        py = clip12((oy * longint'(fl_reg) + longint'(cy_reg) * d) / d);
        return 1'b0;
    endfunction

    function automatic line_item_t project_edge(edge_item_t e);
        longint     sx, cx, sy, cy, px, py, az, qx, qy, bz, num, grey;
        logic [15:0] t;
        line_item_t r;
        sx = sine_lookup(e.angx);
        t  = e.angx + 16'h4000;
        cx = sine_lookup(t);
        sy = sine_lookup(e.angy);
        t  = e.angy + 16'h4000;
        cy = sine_lookup(t);
        r.behind = project_point(e.ax, e.ay, e.az, sx, cx, sy, cy, px, py, az);
        if (project_point(e.bx, e.by, e.bz, sx, cx, sy, cy, qx, qy, bz))
            r.behind = 1'b1;
        num  = 670 * (64'sd1 <<< 40) - 175 * (az + bz);
        grey = (num <= 0) ? 0 : num / (4 * (64'sd1 <<< 40));
        if (grey > 255)
            grey = 255;
        r.sx   = px[11:0];
        r.sy   = py[11:0];
        r.ex   = qx[11:0];
        r.ey   = qy[11:0];
        r.grey = grey[7:0];
        return r;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(9))
            0: case ($urandom_range(3))
                   0: return 16'h8000;
                   1: return 16'h7FFF;
                   2: return 16'h0000;
                   default: return 16'hFFFF;
               endcase
            1, 2: return 16'($urandom);
            default: return 16'($urandom_range(16383)) - 16'd8192;
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(5))
                0: return 16'd0;
                1: return 16'd16383;
                2: return 16'd16384;
                3: return 16'd32768;
                4: return 16'd49152;
                default: return 16'd65535;
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic cfg_write(cfg_reg_t idx, logic [15:0] val);
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        cfg_bus.valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_bus.ready);
        @(posedge clk);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_CENTER_X:      cx_reg = val[9:0];
            REG_CENTER_Y:      cy_reg = val[9:0];
            REG_FOCAL_LENGTH:  fl_reg = val[9:0];
            REG_VIEW_DISTANCE: vd_reg = val;
        endcase
        @(posedge clk);
    endtask

    task automatic send_edge(edge_item_t e, bit typed, line_item_t l);
        int g;
        g = 0;
        while ($urandom_range(99) < send_pct)
            g++;
        if (g > 0)
        begin
            edge_bus.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        edge_bus.a_x     <= e.ax;
        edge_bus.a_y     <= e.ay;
        edge_bus.a_z     <= e.az;
        edge_bus.b_x     <= e.bx;
        edge_bus.b_y     <= e.by;
        edge_bus.b_z     <= e.bz;
        edge_bus.angle_x <= e.angx;
        edge_bus.angle_y <= e.angy;
        edge_bus.valid   <= 1'b1;
        do
            @(negedge clk);
        while (!edge_bus.ready);
        lines_due.push_back(typed ? l : project_edge(e));
        @(posedge clk);
    endtask

    task automatic drain();
        edge_bus.valid <= 1'b0;
        wait (lines_due.size() == 0);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            line_bus.ready <= 1'b0;
        end
        else
            line_bus.ready <= ($urandom_range(99) >= recv_pct);
    end

    always @(negedge clk)
    begin
        line_item_t w;
        if (rst_n && line_bus.valid && line_bus.ready)
        begin
            if (lines_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected line item", $time);
            end
            else
            begin
                w = lines_due.pop_front();
                if (line_bus.start_x !== w.sx)
                begin
                    errors++;
                    $display("%0t: start_x exp %0d got %0d", $time, w.sx, line_bus.start_x);
                end
                if (line_bus.start_y !== w.sy)
                begin
                    errors++;
                    $display("%0t: start_y exp %0d got %0d", $time, w.sy, line_bus.start_y);
                end
                if (line_bus.end_x !== w.ex)
                begin
                    errors++;
                    $display("%0t: end_x exp %0d got %0d", $time, w.ex, line_bus.end_x);
                end
                if (line_bus.end_y !== w.ey)
                begin
                    errors++;
                    $display("%0t: end_y exp %0d got %0d", $time, w.ey, line_bus.end_y);
                end
                if (line_bus.grey_level !== w.grey)
                begin
                    errors++;
                    $display("%0t: grey_level exp %0d got %0d", $time, w.grey,
                             line_bus.grey_level);
                end
                if (line_bus.behind_viewer !== w.behind)
                begin
                    errors++;
                    $display("%0t: behind_viewer exp %0d got %0d", $time, w.behind,
                             line_bus.behind_viewer);
                end
            end
        end
    end

    initial
    begin
        table_row_t rows [$];
        edge_item_t e;
        line_item_t none;
        int         p, n, i;

        errors   = 0;
        cycles   = 0;
        send_pct = 0;
        recv_pct = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        none     = '{default: 0};
        for (i = 0; i <= 256; i++)
            sine_tab[i] = tab_value(i);
        cx_reg = 10'd120;
        cy_reg = 10'd120;
        fl_reg = 10'd180;
        vd_reg = 16'd20480;

        rst_n            = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_CENTER_X;
        cfg_bus.data     = '0;
        edge_bus.valid   = 1'b0;
        edge_bus.a_x     = '0;
        edge_bus.a_y     = '0;
        edge_bus.a_z     = '0;
        edge_bus.b_x     = '0;
        edge_bus.b_y     = '0;
        edge_bus.b_z     = '0;
        edge_bus.angle_x = '0;
        edge_bus.angle_y = '0;
        line_bus.ready   = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ax ay az bx by bz angx angy, typed, expected line
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, '{120, 120, 120, 120, 167, 1'b0}});
        rows.push_back('{'{0, 0, -32768, 0, 0, 0, 0, 0}, 1,
                         '{120, 120, 120, 120, 255, 1'b1}});
        rows.push_back('{'{0, 0, 0, 0, 0, -32768, 0, 0}, 1,
                         '{120, 120, 120, 120, 255, 1'b1}});
        rows.push_back('{'{0, 0, 32767, 0, 0, 32767, 0, 0}, 1,
                         '{120, 120, 120, 120, 0, 1'b0}});
        rows.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767, 0, 0}, 0, none});
        rows.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768, 0, 0}, 0, none});
        rows.push_back('{'{32767, -32768, -16000, -32768, 32767, -16000, 0, 0}, 0, none});
        rows.push_back('{'{4096, 4096, 4096, -4096, -4096, -4096, 16384, 0}, 0, none});
        rows.push_back('{'{4096, 4096, 4096, -4096, -4096, -4096, 32768, 16384}, 0, none});
        rows.push_back('{'{4096, 4096, 4096, -4096, -4096, -4096, 49152, 49152}, 0, none});
        rows.push_back('{'{4096, 4096, 4096, -4096, -4096, -4096, 65535, 65535}, 0, none});
        rows.push_back('{'{4096, 4096, 4096, -4096, -4096, -4096, 16383, 32768}, 0, none});
        rows.push_back('{'{8192, -8192, 0, -8192, 8192, 0, 8192, 40000}, 0, none});
        rows.push_back('{'{0, 0, -32768, 0, 0, -32768, 32768, 32768}, 0, none});
        rows.push_back('{'{-1, -1, -1, 1, 1, 1, 1, 1}, 0, none});
        foreach (rows[k])
            send_edge(rows[k].e, rows[k].typed, rows[k].l);
        drain();

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    cfg_write(REG_CENTER_X, 16'd120);
                    cfg_write(REG_CENTER_Y, 16'd120);
                    cfg_write(REG_FOCAL_LENGTH, 16'd180);
                    cfg_write(REG_VIEW_DISTANCE, 16'd20480);
                    send_pct = 0;
                    recv_pct = 0;
                end
                1:
                begin
                    cfg_write(REG_CENTER_X, 16'd0);
                    cfg_write(REG_CENTER_Y, 16'd0);
                    cfg_write(REG_FOCAL_LENGTH, 16'd1);
                    cfg_write(REG_VIEW_DISTANCE, 16'd1);
                    send_pct = 82;
                    recv_pct = 0;
                end
                2:
                begin
                    cfg_write(REG_CENTER_X, 16'd1023);
                    cfg_write(REG_CENTER_Y, 16'd1023);
                    cfg_write(REG_FOCAL_LENGTH, 16'd1023);
                    cfg_write(REG_VIEW_DISTANCE, 16'd65535);
                    send_pct = 0;
                    recv_pct = 82;
                end
                3:
                begin
                    cfg_write(REG_CENTER_X, 16'hFFFF);
                    cfg_write(REG_CENTER_Y, 16'hFC00);
                    cfg_write(REG_FOCAL_LENGTH, 16'($urandom));
                    cfg_write(REG_VIEW_DISTANCE, 16'($urandom));
                    send_pct = 37;
                    recv_pct = 37;
                end
                4:
                begin
                    cfg_write(REG_FOCAL_LENGTH, 16'd0);
                    cfg_write(REG_VIEW_DISTANCE, 16'd0);
                    send_pct = 37;
                    recv_pct = 37;
                end
                default:
                begin
                    cfg_write(REG_CENTER_X, 16'($urandom));
                    cfg_write(REG_CENTER_Y, 16'($urandom));
                    cfg_write(REG_FOCAL_LENGTH, 16'($urandom_range(1023, 1)));
                    cfg_write(REG_VIEW_DISTANCE, 16'($urandom_range(65535, 1)));
                    send_pct = 0;
                    recv_pct = 0;
                end
            endcase
            for (n = 0; n < 100; n++)
            begin
                if (p == 0 && n == 40)
                    hold_req = 1'b1;
                if (p == 1 && n == 50)
                begin
                    edge_bus.valid <= 1'b0;
                    wait (lines_due.size() == 0);
                    @(posedge clk);
                end
                e.ax   = rand_coord();
                e.ay   = rand_coord();
                e.az   = rand_coord();
                e.bx   = rand_coord();
                e.by   = rand_coord();
                e.bz   = rand_coord();
                e.angx = rand_angle();
                e.angy = rand_angle();
                send_edge(e, 0, none);
            end
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ edge_rotate_project_unit.f @@
rtl/core/erp_pkg.sv
rtl/core/erp_ifs.sv
rtl/core/erp_sine.sv
rtl/core/erp_rotate.sv
rtl/core/erp_proj.sv
rtl/core/edge_rotate_project_unit.sv
tb/testbench.sv
